### rtl/waypoint_steering_controller_macros.svh
// Assertion macros for the waypoint steering controller checker.
// Depends on nothing; included by wsc_checker.sv.
`ifndef WAYPOINT_STEERING_CONTROLLER_MACROS_SVH
`define WAYPOINT_STEERING_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WSC_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/wsc_pkg.sv
// Shared constants and the arctangent table of the waypoint steering controller.
// Depends on nothing; used by wsc_cordic and waypoint_steering_controller.
package wsc_pkg;

    // angle width, signed Q3.13
    localparam int ANG_W = 16;
    // CORDIC datapath widths: bearing from 17-bit deltas, heading from Q2.28 products
    localparam int BRG_W = 20;
    localparam int HDG_W = 36;
    // heading error width
    localparam int ERR_W = 17;

    localparam logic signed [ANG_W-1:0] ANG_PI      = 16'sd25736;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 16'sd12868;

    localparam logic signed [ERR_W-1:0] ERR_PI      = 17'sd25736;
    localparam logic signed [ERR_W-1:0] ERR_TWO_PI  = 17'sd51472;
    localparam logic [ERR_W-1:0]        ALIGN_LIMIT = 17'd819;

    // 0.08 in Q0.16, with round-half-up
    localparam logic [29:0] SLOW_FACTOR = 30'd5243;
    localparam logic [29:0] SLOW_ROUND  = 30'd32768;

    // register map
    localparam logic [0:0] REG_CRUISE_SPEED = 1'b0;
    localparam logic [0:0] REG_ARRIVE_TOL   = 1'b1;

    localparam logic [15:0] CRUISE_RESET = 16'd1229;
    localparam logic [14:0] TOL_RESET    = 15'd26;

    // atan(2^-i) in Q3.13
    function automatic logic signed [ANG_W-1:0] atan_q13(input int unsigned idx);
        logic signed [ANG_W-1:0] r;
        case (idx)
            0:       r = 16'sd6434;
            1:       r = 16'sd3798;
            2:       r = 16'sd2007;
            3:       r = 16'sd1019;
            4:       r = 16'sd511;
            5:       r = 16'sd256;
            6:       r = 16'sd128;
            7:       r = 16'sd64;
            8:       r = 16'sd32;
            9:       r = 16'sd16;
            10:      r = 16'sd8;
            11:      r = 16'sd4;
            12:      r = 16'sd2;
            13:      r = 16'sd1;
            default: r = 16'sd0;
        endcase
        return r;
    endfunction

endpackage

### rtl/wsc_cordic.sv
// Pipelined vectoring CORDIC atan2: quarter-turn pre-rotation, one iteration per stage.
// Depends on wsc_pkg; stage loads are driven by the top level's pipeline control.
module wsc_cordic #(
    parameter int W      = 36,
    parameter int STAGES = 16
) (
    input  logic                             clk,
    input  logic [STAGES:0]                  ld,
    input  logic signed [W-1:0]              x_in,
    input  logic signed [W-1:0]              y_in,
    output logic signed [wsc_pkg::ANG_W-1:0] angle
);

    logic signed [W-1:0]              x_reg    [0:STAGES];
    logic signed [W-1:0]              y_reg    [0:STAGES];
    logic signed [wsc_pkg::ANG_W-1:0] z_reg    [0:STAGES];
    logic                             zero_reg [0:STAGES];

    // pre-rotation into the right half plane
    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in[W-1])
            begin
                if (!y_in[W-1])
                begin
                    x_reg[0] <= y_in;
                    y_reg[0] <= -x_in;
                    z_reg[0] <= wsc_pkg::ANG_HALF_PI;
                end
                else
                begin
                    x_reg[0] <= -y_in;
                    y_reg[0] <= x_in;
                    z_reg[0] <= -wsc_pkg::ANG_HALF_PI;
                end
            end
            else
            begin
                x_reg[0] <= x_in;
                y_reg[0] <= y_in;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_iter
        logic signed [W-1:0] xs;
        logic signed [W-1:0] ys;

        // floor shifts
        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (ld[i+1])
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (!y_reg[i][W-1])
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + wsc_pkg::atan_q13(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - wsc_pkg::atan_q13(i);
                end
            end
        end
    end

    // zero vector gives 0; otherwise clamp to [-pi, pi]
    always_comb
    begin
        if (zero_reg[STAGES])
            angle = '0;
        else if (z_reg[STAGES] > wsc_pkg::ANG_PI)
            angle = wsc_pkg::ANG_PI;
        else if (z_reg[STAGES] < -wsc_pkg::ANG_PI)
            angle = -wsc_pkg::ANG_PI;
        else
            angle = z_reg[STAGES];
    end

endmodule

### rtl/waypoint_steering_controller.sv
// An accepted request reaches the outputs through the stages listed in the stage map below.
// Throughput: one request per cycle; each stage holds only while it and all stages after it
// are full and the output is not taken, so bubbles collapse and the input keeps flowing.
// The rate is set by the two unrolled CORDIC pipelines, one iteration per stage.
// Reset (rst_n low, asynchronous) empties the pipeline and restores both config registers;
// datapath registers are not reset.
module waypoint_steering_controller #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration write port
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    // request channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [15:0] quat_z,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] goal_x,
    input  logic signed [15:0] goal_y,
    // result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [16:0] turn_rate,
    output logic [15:0]        drive_speed,
    output logic               arrived,
    output logic               aligned
);

    // Stage map:
    //   0                  : deltas to goal, quaternion products
    //   1                  : CORDIC pre-rotation, box tests
    //   2 .. STAGES+1      : CORDIC iterations
    //   STAGES+2           : clamp, heading error and wrap, slow-turn magnitude
    //   STAGES+3           : command selection, output register
    localparam int NUM_ST = CORDIC_STAGES + 4;
    localparam int ERR_ST = CORDIC_STAGES + 2;
    localparam int OUT_ST = CORDIC_STAGES + 3;
    localparam int BW     = wsc_pkg::BRG_W;
    localparam int HW     = wsc_pkg::HDG_W;
    localparam int EW     = wsc_pkg::ERR_W;

    typedef struct packed {
        logic in_box;
        logic in_near;
    } box_t;

    // ---------------------------------------------------------------
    // Pipeline control: a stage may load when it, or any stage after it,
    // is empty, or when the output is being taken.
    // ---------------------------------------------------------------
    logic [NUM_ST-1:0] v_reg;
    logic [NUM_ST-1:0] adv;

    for (genvar k = 0; k < NUM_ST; k++)
    begin : g_adv
        assign adv[k] = out_ready | ~(&v_reg[NUM_ST-1:k]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k < NUM_ST; k++)
            begin
                if (adv[k])
                    v_reg[k] <= v_reg[k-1];
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[OUT_ST];

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [15:0] cruise_reg;
    logic [14:0] tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cruise_reg <= wsc_pkg::CRUISE_RESET;
            tol_reg    <= wsc_pkg::TOL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wsc_pkg::REG_CRUISE_SPEED: cruise_reg <= cfg_wdata;
                wsc_pkg::REG_ARRIVE_TOL:   tol_reg    <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Stage 0: goal deltas and quaternion products (Q2.28, exact)
    // ---------------------------------------------------------------
    logic signed [16:0] dx_reg;
    logic signed [16:0] dy_reg;
    logic signed [31:0] ww_reg;
    logic signed [31:0] zz_reg;
    logic signed [31:0] wz_reg;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            dx_reg <= 17'(goal_x) - 17'(pos_x);
            dy_reg <= 17'(goal_y) - 17'(pos_y);
            ww_reg <= quat_w * quat_w;
            zz_reg <= quat_z * quat_z;
            wz_reg <= quat_w * quat_z;
        end
    end

    // heading vector: (w*w - z*z, 2*w*z)
    logic signed [BW-1:0] brg_x;
    logic signed [BW-1:0] brg_y;
    logic signed [HW-1:0] hdg_x;
    logic signed [HW-1:0] hdg_y;

    assign brg_x = BW'(dx_reg);
    assign brg_y = BW'(dy_reg);
    assign hdg_x = HW'(ww_reg) - HW'(zz_reg);
    assign hdg_y = HW'(wz_reg) <<< 1;

    // ---------------------------------------------------------------
    // Stage 1: arrival and slow-down box tests, then carried alongside
    // the CORDIC pipelines up to the error stage
    // ---------------------------------------------------------------
    logic [16:0] ax;
    logic [16:0] ay;
    logic [17:0] near_lim;
    box_t        box_reg [1:ERR_ST];

    assign ax       = dx_reg[16] ? 17'(-dx_reg) : 17'(dx_reg);
    assign ay       = dy_reg[16] ? 17'(-dy_reg) : 17'(dy_reg);
    assign near_lim = 18'({tol_reg, 2'b00}) + 18'(tol_reg);

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            box_reg[1].in_box  <= (ax <= 17'(tol_reg)) && (ay <= 17'(tol_reg));
            box_reg[1].in_near <= (18'(ax) <= near_lim) && (18'(ay) <= near_lim);
        end
        for (int k = 2; k <= ERR_ST; k++)
        begin
            if (adv[k])
                box_reg[k] <= box_reg[k-1];
        end
    end

    // ---------------------------------------------------------------
    // Stages 1 .. STAGES+1: bearing and heading CORDICs side by side
    // ---------------------------------------------------------------
    logic signed [wsc_pkg::ANG_W-1:0] brg_angle;
    logic signed [wsc_pkg::ANG_W-1:0] hdg_angle;

    wsc_cordic #(
        .W      (BW),
        .STAGES (CORDIC_STAGES)
    ) u_brg_cordic (
        .clk   (clk),
        .ld    (adv[CORDIC_STAGES+1:1]),
        .x_in  (brg_x),
        .y_in  (brg_y),
        .angle (brg_angle)
    );

    wsc_cordic #(
        .W      (HW),
        .STAGES (CORDIC_STAGES)
    ) u_hdg_cordic (
        .clk   (clk),
        .ld    (adv[CORDIC_STAGES+1:1]),
        .x_in  (hdg_x),
        .y_in  (hdg_y),
        .angle (hdg_angle)
    );

    // ---------------------------------------------------------------
    // Error stage: bearing minus heading, wrapped into [-pi, pi];
    // slow-turn magnitude 0.08 * cruise, rounded
    // ---------------------------------------------------------------
    logic signed [EW-1:0] err_raw;
    logic signed [EW-1:0] err_wrap;
    logic [29:0]          slow_prod;
    logic signed [EW-1:0] err_reg;
    logic [15:0]          slow_reg;

    assign err_raw   = EW'(brg_angle) - EW'(hdg_angle);
    assign slow_prod = 30'(cruise_reg) * wsc_pkg::SLOW_FACTOR + wsc_pkg::SLOW_ROUND;

    always_comb
    begin
        if (err_raw > wsc_pkg::ERR_PI)
            err_wrap = err_raw - wsc_pkg::ERR_TWO_PI;
        else if (err_raw < -wsc_pkg::ERR_PI)
            err_wrap = err_raw + wsc_pkg::ERR_TWO_PI;
        else
            err_wrap = err_raw;
    end

    always_ff @(posedge clk)
    begin
        if (adv[ERR_ST])
        begin
            err_reg  <= err_wrap;
            slow_reg <= 16'(slow_prod[29:16]);
        end
    end

    // ---------------------------------------------------------------
    // Output stage: alignment, turn sign and drive selection
    // ---------------------------------------------------------------
    logic [EW-1:0]        abs_err;
    logic                 is_aligned;
    logic [15:0]          mag;
    logic signed [16:0]   turn_sel;
    logic [15:0]          drive_sel;
    box_t                 box_e;

    logic signed [16:0]   turn_reg;
    logic [15:0]          drive_reg;
    logic                 arrived_reg;
    logic                 aligned_reg;

    assign box_e      = box_reg[ERR_ST];
    assign abs_err    = err_reg[EW-1] ? EW'(-err_reg) : EW'(err_reg);
    assign is_aligned = abs_err <= wsc_pkg::ALIGN_LIMIT;
    assign mag        = is_aligned ? slow_reg : cruise_reg;

    always_comb
    begin
        // zero error means no turn
        if (err_reg == '0)
            turn_sel = '0;
        else if (err_reg[EW-1])
            turn_sel = -$signed({1'b0, mag});
        else
            turn_sel = $signed({1'b0, mag});

        if (!is_aligned || box_e.in_box)
            drive_sel = '0;
        else if (box_e.in_near)
            drive_sel = cruise_reg >> 1;
        else
            drive_sel = cruise_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv[OUT_ST])
        begin
            turn_reg    <= turn_sel;
            drive_reg   <= drive_sel;
            arrived_reg <= is_aligned && box_e.in_box;
            aligned_reg <= is_aligned;
        end
    end

    assign turn_rate   = turn_reg;
    assign drive_speed = drive_reg;
    assign arrived     = arrived_reg;
    assign aligned     = aligned_reg;

endmodule

### rtl/wsc_checker.sv
// Port-level checker for the waypoint steering controller, bound to the top level.
// Depends on waypoint_steering_controller_macros.svh.
`include "waypoint_steering_controller_macros.svh"

module wsc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [16:0] turn_rate,
    input logic [15:0]        drive_speed,
    input logic               arrived,
    input logic               aligned
);

    logic        res_arrived;
    logic        arrive_ok;
    logic        res_misaligned;
    logic        idle_ok;
    logic        res_stalled;
    logic [34:0] res_bits;

    assign res_arrived    = out_valid && arrived;
    assign arrive_ok      = aligned && (drive_speed == 16'd0);
    assign res_misaligned = out_valid && !aligned;
    assign idle_ok        = (drive_speed == 16'd0) && !arrived;
    assign res_stalled    = out_valid && !out_ready;
    assign res_bits       = {turn_rate, drive_speed, arrived, aligned};

    // arrival needs alignment and always stops the robot
    `WSC_ASSERT_IMP(a_arrived_stops, clk, rst_n, res_arrived, arrive_ok, "arrived while driving")

    // no forward drive and no arrival while misaligned
    `WSC_ASSERT_IMP(a_misaligned_idle, clk, rst_n, res_misaligned, idle_ok, "misaligned result moves")

    // a stalled result stays offered
    `WSC_ASSERT_NXT(a_out_hold, clk, rst_n, res_stalled, out_valid, "result withdrawn before taken")

    // and keeps its payload
    `WSC_ASSERT_NXT(a_out_stable, clk, rst_n, res_stalled, $stable(res_bits), "stalled result changed")

endmodule

bind waypoint_steering_controller wsc_checker u_wsc_checker (.*);
